// ----- sv/fbc_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fbc_pkg
// Shared widths, types and codes for the view-volume box culling block.
// -----------------------------------------------------------------------------
package fbc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_BITS = 16;
  localparam int PIDX_W     = $clog2(NUM_PLANES);
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int OFF_W      = 2 * COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [OFF_W-1:0]      off_t;

  // Item kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  // Operation issued to the dot unit
  typedef struct packed {
    logic valid;  // operands present this cycle
    logic test;   // pick the best corner instead of using the second vector
  } fbc_op_t;

endpackage

// ----- sv/fbc_dot.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fbc_dot
// Shared three-multiplier dot product unit with corner selection.
// -----------------------------------------------------------------------------
module fbc_dot import fbc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  fbc_op_t op_i,
  input  coord_t  normal_i [3],
  input  coord_t  first_i  [3],
  input  coord_t  second_i [3],
  output logic    sum_valid_o,
  output off_t    sum_o
);

  coord_t corner [3];
  prod_t  prod_d [3];
  prod_t  prod_q [3];
  logic   valid_q;

  // Per axis take the value that maximizes normal * coordinate in a test; else the second vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op_i.test && ((normal_i[i] >= 0) != (first_i[i] >= second_i[i]))) begin
        corner[i] = second_i[i];
      end else if (op_i.test) begin
        corner[i] = first_i[i];
      end else begin
        corner[i] = second_i[i];
      end
      prod_d[i] = prod_t'(normal_i[i]) * prod_t'(corner[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

  assign sum_valid_o = valid_q;
  assign sum_o       = off_t'(prod_q[0]) + off_t'(prod_q[1]) + off_t'(prod_q[2]);

endmodule

// ----- sv/frustum_box_cull.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// frustum_box_cull
// View-volume culling of axis-aligned boxes against stored planes.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item. A load item
//   (kind 0) writes the normal and offset of one plane; loads to an index at
//   or above the plane count are dropped. A test item (kind 1) gives two box
//   corners and returns one visible bit on the output channel
//   (out_valid_o / out_ready_i). Loads return nothing.
// Timing:
//   A load passes through the LOAD and LWRITE states. A test issues one plane
//   per cycle into the shared three-multiplier dot unit (from plane 1 with
//   skip_far), then goes through WAIT to FINISH, where the result register
//   loads, and back to IDLE for the next item. Products are registered,
//   then summed and compared against the plane offset in the following cycle.
// Reset:
//   All planes clear to zero; a zero plane never culls. Output is empty.
// Stall:
//   A finished result sits in the output register; the block takes the next
//   item meanwhile, and holds a new test result until that register frees.
// -----------------------------------------------------------------------------
module frustum_box_cull import fbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [2:0]  plane_index_i,
  input  coord_t      first_x_i,
  input  coord_t      first_y_i,
  input  coord_t      first_z_i,
  input  coord_t      second_x_i,
  input  coord_t      second_y_i,
  input  coord_t      second_z_i,
  input  logic        skip_far_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        visible_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LWRITE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // Latched item
  logic              kind_q;
  logic [2:0]        idx_q;
  logic              skip_q;
  coord_t            a_q [3];
  coord_t            b_q [3];

  // Plane store
  coord_t            normals_q [NUM_PLANES][3];
  off_t              offsets_q [NUM_PLANES];

  // Sequencer
  logic [PIDX_W-1:0] p_q, p_d;    // plane being issued
  logic [PIDX_W-1:0] pp_q;        // plane whose products are in flight
  logic              vis_q, vis_d;
  logic              out_valid_q, out_valid_d;
  logic              visible_q, visible_d;

  // Dot unit hookup
  fbc_op_t           op;
  coord_t            dot_normal [3];
  logic              sum_valid;
  off_t              sum;

  logic              accept;
  logic              load_ok;

  assign accept  = in_valid_i && in_ready_o;
  assign load_ok = int'(idx_q) < NUM_PLANES;

  always_comb begin
    op.valid = (state_q == ST_LOAD) || (state_q == ST_ISSUE);
    op.test  = (state_q == ST_ISSUE);
    for (int i = 0; i < 3; i++) begin
      dot_normal[i] = (state_q == ST_ISSUE) ? normals_q[p_q][i] : a_q[i];
    end
  end

  fbc_dot u_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .normal_i    (dot_normal),
    .first_i     (a_q),
    .second_i    (b_q),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    vis_d       = vis_q;
    out_valid_d = out_valid_q;
    visible_d   = visible_q;

    // Retire the output register when taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Fold one plane's verdict: the best corner is behind this plane
    if (sum_valid && (kind_q == KIND_TEST) && (sum < offsets_q[pp_q])) begin
      vis_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_TEST) begin
            state_d = ST_ISSUE;
            p_d     = skip_far_i ? PIDX_W'(1) : '0;
            vis_d   = 1'b1;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        state_d = ST_LWRITE;
      end
      ST_LWRITE: begin
        state_d = ST_IDLE;
      end
      ST_ISSUE: begin
        if (p_q == PIDX_W'(NUM_PLANES - 1)) begin
          state_d = ST_WAIT;
        end else begin
          p_d = p_q + PIDX_W'(1);
        end
      end
      ST_WAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          visible_d   = vis_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      pp_q        <= '0;
      vis_q       <= 1'b1;
      out_valid_q <= 1'b0;
      visible_q   <= 1'b0;
      kind_q      <= KIND_LOAD;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      vis_q       <= vis_d;
      out_valid_q <= out_valid_d;
      visible_q   <= visible_d;
      if (op.valid) begin
        pp_q <= p_q;
      end
      if (accept) begin
        kind_q <= kind_i;
      end
    end
  end

  // Item payload latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q  <= plane_index_i;
      skip_q <= skip_far_i;
      a_q[0] <= first_x_i;
      a_q[1] <= first_y_i;
      a_q[2] <= first_z_i;
      b_q[0] <= second_x_i;
      b_q[1] <= second_y_i;
      b_q[2] <= second_z_i;
    end
  end

  // Plane store: write normal and offset once the load's dot product lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int i = 0; i < 3; i++) begin
          normals_q[p][i] <= '0;
        end
        offsets_q[p] <= '0;
      end
    end else if ((state_q == ST_LWRITE) && load_ok) begin
      for (int i = 0; i < 3; i++) begin
        normals_q[idx_q[PIDX_W-1:0]][i] <= a_q[i];
      end
      offsets_q[idx_q[PIDX_W-1:0]] <= sum;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  // Products only arrive while an item is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid |-> (state_q == ST_LWRITE || state_q == ST_ISSUE || state_q == ST_WAIT))
    else $error("dot result outside of an item");

  // A new result only ever comes from a test item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> (kind_q == KIND_TEST))
    else $error("result produced by a load");

  // The far plane never votes when it is skipped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid && kind_q == KIND_TEST && skip_q) |-> (pp_q != '0))
    else $error("far plane tested despite skip");

  // No product is in flight when a new item can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sum_valid)
    else $error("ready while dot unit busy");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for frustum_box_cull: loads view-volume planes, tests
// boxes and points against them, and compares every visible bit with a
// plane-by-plane prediction kept alongside the block under random flow control.
// -----------------------------------------------------------------------------
import fbc_pkg::*;

typedef struct packed {
  logic       kind;
  logic [2:0] plane_index;
  coord_t     first_x;
  coord_t     first_y;
  coord_t     first_z;
  coord_t     second_x;
  coord_t     second_y;
  coord_t     second_z;
  logic       skip_far;
} cull_item_t;

// Keeps its own copy of the planes and a queue of the visible bits to come.
class visibility_board;
  coord_t plane_n [NUM_PLANES][3];
  off_t   plane_off [NUM_PLANES];
  bit     visible_q [$];
  int     errors;
  int     loads;
  int     dropped_loads;
  int     tests;
  int     culled;
  int     skipped_far;

  function new();
    foreach (plane_n[p, i]) plane_n[p][i] = '0;
    foreach (plane_off[p]) plane_off[p] = '0;
  endfunction

  function longint sx(coord_t v);
    return longint'(v);
  endfunction

  // A box is culled once some plane in use has the best corner behind it.
  function bit predict_visible(cull_item_t it);
    longint lo [3];
    longint hi [3];
    longint n;
    longint best;
    lo[0] = sx(it.first_x);
    lo[1] = sx(it.first_y);
    lo[2] = sx(it.first_z);
    hi[0] = sx(it.second_x);
    hi[1] = sx(it.second_y);
    hi[2] = sx(it.second_z);
    for (int p = (it.skip_far ? 1 : 0); p < NUM_PLANES; p++) begin
      best = 0;
      for (int i = 0; i < 3; i++) begin
        n = sx(plane_n[p][i]);
        best += (n * lo[i] > n * hi[i]) ? n * lo[i] : n * hi[i];
      end
      if (best < longint'(plane_off[p])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_item(cull_item_t it);
    longint off;
    bit     vis;
    if (it.kind == KIND_LOAD) begin
      loads++;
      if (it.plane_index >= NUM_PLANES) begin
        dropped_loads++;
        return;
      end
      plane_n[it.plane_index][0] = it.first_x;
      plane_n[it.plane_index][1] = it.first_y;
      plane_n[it.plane_index][2] = it.first_z;
      off = sx(it.first_x) * sx(it.second_x) + sx(it.first_y) * sx(it.second_y)
          + sx(it.first_z) * sx(it.second_z);
      plane_off[it.plane_index] = off_t'(off);
    end else begin
      vis = predict_visible(it);
      tests++;
      if (!vis) culled++;
      if (it.skip_far) skipped_far++;
      visible_q.push_back(vis);
    end
  endfunction

  function void check_visible(logic got);
    bit want;
    if (visible_q.size() == 0) begin
      $error("visible: result with no expectation waiting, actual %0d", got);
      errors++;
      return;
    end
    want = visible_q.pop_front();
    if (got !== want) begin
      $error("visible: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return visible_q.size();
  endfunction
endclass

module tb;

  localparam int RANDOM_ITEMS = 1000;
  localparam int RX_HOLD      = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 30;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  logic   kind_i;
  logic [2:0] plane_index_i;
  coord_t first_x_i;
  coord_t first_y_i;
  coord_t first_z_i;
  coord_t second_x_i;
  coord_t second_y_i;
  coord_t second_z_i;
  logic   skip_far_i;
  logic   out_valid_o;
  logic   out_ready_i;
  logic   visible_o;

  visibility_board sb;
  int idle_cycles = 0;
  int items_done  = 0;
  int hold_seq    = 0;
  int hold_seen   = 0;
  logic rx_holding = 1'b0;

  frustum_box_cull i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .plane_index_i (plane_index_i),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .first_z_i     (first_z_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .second_z_i    (second_z_i),
    .skip_far_i    (skip_far_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .visible_o     (visible_o)
  );

  always #5 clk_i = ~clk_i;

  // Monitor both channels; values read here are the ones held before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_item({kind_i, plane_index_i, first_x_i, first_y_i, first_z_i,
                      second_x_i, second_y_i, second_z_i, skip_far_i});
      end
      if (out_valid_o && out_ready_i) sb.check_visible(visible_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Full-range value when span is zero, else uniform in -span..span.
  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic cull_item_t mk(logic kind, int idx, int ax, int ay, int az,
                                    int bx, int by, int bz, logic skip);
    cull_item_t it;
    it.kind        = kind;
    it.plane_index = 3'(idx);
    it.first_x     = coord_t'(ax);
    it.first_y     = coord_t'(ay);
    it.first_z     = coord_t'(az);
    it.second_x    = coord_t'(bx);
    it.second_y    = coord_t'(by);
    it.second_z    = coord_t'(bz);
    it.skip_far    = skip;
    return it;
  endfunction

  function automatic cull_item_t rnd_load(int nspan, int pspan);
    cull_item_t it;
    int idx;
    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_PLANES, 7)
                                      : $urandom_range(0, NUM_PLANES - 1);
    it = mk(KIND_LOAD, idx, 0, 0, 0, 0, 0, 0, 1'($urandom));
    if ($urandom_range(0, 19) != 0) begin
      it.first_x = rnd_coord(nspan);
      it.first_y = rnd_coord(nspan);
      it.first_z = rnd_coord(nspan);
    end
    it.second_x = rnd_coord(pspan);
    it.second_y = rnd_coord(pspan);
    it.second_z = rnd_coord(pspan);
    return it;
  endfunction

  function automatic cull_item_t rnd_test(int span);
    cull_item_t it;
    it = mk(KIND_TEST, $urandom_range(0, 7), 0, 0, 0, 0, 0, 0, 1'($urandom));
    it.first_x  = rnd_coord(span);
    it.first_y  = rnd_coord(span);
    it.first_z  = rnd_coord(span);
    if ($urandom_range(0, 6) == 0) begin
      // point test
      it.second_x = it.first_x;
      it.second_y = it.first_y;
      it.second_z = it.first_z;
    end else begin
      it.second_x = rnd_coord(span);
      it.second_y = rnd_coord(span);
      it.second_z = rnd_coord(span);
    end
    return it;
  endfunction

  // Offer one item and hold it until accepted; returns on the accepting edge.
  task automatic send_item(input cull_item_t it);
    kind_i        <= it.kind;
    plane_index_i <= it.plane_index;
    first_x_i     <= it.first_x;
    first_y_i     <= it.first_y;
    first_z_i     <= it.first_z;
    second_x_i    <= it.second_x;
    second_y_i    <= it.second_y;
    second_z_i    <= it.second_z;
    skip_far_i    <= it.skip_far;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (!(it.kind == KIND_LOAD && it.plane_index >= NUM_PLANES)) items_done++;
  endtask

  task automatic pause_in(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every outstanding visible bit.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: ready runs broken by stalls, plus the long hold-off on request.
  initial begin
    int run;
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ready_i <= 1'b0;
        rx_holding  <= 1'b1;
        repeat (RX_HOLD) @(posedge clk_i);
        rx_holding  <= 1'b0;
      end
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    cull_item_t it;
    int round;
    int nloads;
    int ntests;
    int span;
    int nspan;
    bit no_gaps;
    sb = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_LOAD;
    plane_index_i = '0;
    first_x_i     = '0;
    first_y_i     = '0;
    first_z_i     = '0;
    second_x_i    = '0;
    second_y_i    = '0;
    second_z_i    = '0;
    skip_far_i    = 1'b0;
    out_ready_i   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero planes after reset never cull.
    send_item(mk(KIND_TEST, 0, -32768, -32768, -32768, 32767, 32767, 32767, 1'b0));
    send_item(mk(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    // A small view volume looking down -z: far, near, then four sides.
    send_item(mk(KIND_LOAD, 0, 0, 0, 1, 0, 0, -1000, 1'b0));
    send_item(mk(KIND_LOAD, 1, 0, 0, -1, 0, 0, -1, 1'b0));
    send_item(mk(KIND_LOAD, 2, 1, 0, -1, 0, 0, 0, 1'b0));
    send_item(mk(KIND_LOAD, 3, -1, 0, -1, 0, 0, 0, 1'b0));
    send_item(mk(KIND_LOAD, 4, 0, 1, -1, 0, 0, 0, 1'b0));
    send_item(mk(KIND_LOAD, 5, 0, -1, -1, 0, 0, 0, 1'b0));
    send_item(mk(KIND_TEST, 0, -10, -10, -50, 10, 10, -40, 1'b0));
    // same box with its corners swapped
    send_item(mk(KIND_TEST, 0, 10, 10, -40, -10, -10, -50, 1'b0));
    send_item(mk(KIND_TEST, 0, -10, -10, 10, 10, 10, 20, 1'b0));
    // beyond the far plane: culled, then visible with the far plane skipped
    send_item(mk(KIND_TEST, 0, -10, -10, -2000, 10, 10, -1500, 1'b0));
    send_item(mk(KIND_TEST, 0, -10, -10, -2000, 10, 10, -1500, 1'b1));
    send_item(mk(KIND_TEST, 0, 0, 0, -5, 0, 0, -5, 1'b0));
    send_item(mk(KIND_TEST, 0, 100, 0, -5, 100, 0, -5, 1'b0));
    // loads past the plane count are dropped
    send_item(mk(KIND_LOAD, 6, 5, 5, 5, 100, 100, 100, 1'b0));
    send_item(mk(KIND_LOAD, 7, -7, 3, 1, 32767, -32768, 1, 1'b1));
    send_item(mk(KIND_TEST, 0, 0, 0, -5, 0, 0, -5, 1'b0));
    // extreme normals and points: largest and smallest offsets
    send_item(mk(KIND_LOAD, 2, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0));
    send_item(mk(KIND_TEST, 0, -32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
    send_item(mk(KIND_TEST, 0, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
    send_item(mk(KIND_LOAD, 3, 32767, 32767, 32767, -32768, -32768, -32768, 1'b1));
    send_item(mk(KIND_TEST, 0, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
    send_item(mk(KIND_TEST, 0, 32767, -32768, 0, -32768, 32767, 0, 1'b0));
    drain();

    // Random rounds: a set of planes, then boxes against them, a few stray loads.
    items_done = 0;
    round = 0;
    while (items_done < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: begin span = 0;   nspan = 0;  end
        1: begin span = 300; nspan = 4;  end
        default: begin span = 2000; nspan = 64; end
      endcase
      nloads = $urandom_range(0, NUM_PLANES + 1);
      ntests = $urandom_range(4, 30);
      for (int k = 0; k < nloads; k++) begin
        send_item(rnd_load(nspan, span));
        pause_in(no_gaps ? 0 : pick_gap());
      end
      if (round == 8) begin
        // Long receiver hold-off while the sender keeps pushing tests.
        pause_in(1);
        hold_seq++;
        while (!rx_holding) @(posedge clk_i);
        for (int k = 0; k < 30; k++) send_item(rnd_test(span));
        drain();
      end
      for (int k = 0; k < ntests; k++) begin
        it = ($urandom_range(0, 9) == 0) ? rnd_load(nspan, span) : rnd_test(span);
        send_item(it);
        pause_in(no_gaps ? 0 : pick_gap());
      end
      if ($urandom_range(0, 4) == 0) drain();
      round++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d plane loads (%0d to unused indexes) and %0d box tests",
             sb.loads, sb.dropped_loads, sb.tests);
    $display("Results: %0d visible, %0d culled, %0d tests with the far plane skipped",
             sb.tests - sb.culled, sb.culled, sb.skipped_far);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
